### hw/rtl/u8250_pkg.sv
// ----------------------------------------------------------------------------
// u8250_pkg
// Shared codes, register bit positions and the command word passed from the
// front decoder to the execution back end of the 8250 register model.
// ----------------------------------------------------------------------------
package u8250_pkg;

    // item kinds on the input channel
    localparam logic [1:0] MODE_READ  = 2'd0;
    localparam logic [1:0] MODE_WRITE = 2'd1;
    localparam logic [1:0] MODE_RX    = 2'd2;
    localparam logic [1:0] MODE_TAKE  = 2'd3;

    // register offsets
    localparam logic [2:0] OFS_DATA = 3'd0;
    localparam logic [2:0] OFS_IER  = 3'd1;
    localparam logic [2:0] OFS_IIR  = 3'd2;
    localparam logic [2:0] OFS_LCR  = 3'd3;
    localparam logic [2:0] OFS_MCR  = 3'd4;
    localparam logic [2:0] OFS_LSR  = 3'd5;
    localparam logic [2:0] OFS_MSR  = 3'd6;
    localparam logic [2:0] OFS_SCR  = 3'd7;

    // register bits
    localparam int LCR_DLAB_BIT = 7;
    localparam int LSR_DR_BIT   = 0;
    localparam int LSR_OE_BIT   = 1;
    localparam int LSR_THRE_BIT = 5;
    localparam int LSR_TEMT_BIT = 6;
    localparam int IER_RX_BIT   = 0;
    localparam int IER_TX_BIT   = 1;
    localparam int MCR_DTR_BIT  = 0;
    localparam int MCR_RTS_BIT  = 1;
    localparam int MCR_OUT2_BIT = 3;
    localparam int MCR_LOOP_BIT = 4;

    localparam logic [7:0] LSR_KEEP_MASK = 8'h61;
    localparam logic [7:0] MSR_KEEP_MASK = 8'hF0;

    // interrupt identification codes
    localparam logic [7:0] IIR_NONE = 8'h01;
    localparam logic [7:0] IIR_THRE = 8'h02;
    localparam logic [7:0] IIR_RDA  = 8'h04;

    // reset values
    localparam logic [15:0] DIVISOR_RST = 16'd12;
    localparam logic [7:0]  LSR_RST     = 8'h60;
    localparam logic [7:0]  MSR_RST     = 8'h30;

    // command queue between front and back
    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = 1;
    localparam int Q_CNT_W = 2;

    typedef enum logic [4:0] {
        OP_RD_RBR,
        OP_RD_IER,
        OP_RD_IIR,
        OP_RD_LCR,
        OP_RD_MCR,
        OP_RD_LSR,
        OP_RD_MSR,
        OP_RD_SCR,
        OP_WR_THR,
        OP_WR_IER,
        OP_WR_FCR,
        OP_WR_LCR,
        OP_WR_MCR,
        OP_WR_SCR,
        OP_WR_NONE,
        OP_LINE_RX,
        OP_TX_TAKE
    } op_t;

    typedef struct packed {
        op_t        op;
        logic [7:0] data;
    } cmd_t;

    typedef struct packed {
        logic       thre;
        logic       irq;
        logic [7:0] iir;
    } bk_stat_t;

endpackage

### hw/rtl/u8250_front.sv
// ----------------------------------------------------------------------------
// u8250_front
// Accepts input words and classifies them into back end commands.
// ----------------------------------------------------------------------------
module u8250_front import u8250_pkg::*; (
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [1:0] s_mode,
    input  logic [2:0] s_reg_offset,
    input  logic [7:0] s_data,
    input  logic       q_full,
    output logic       q_push,
    output cmd_t       q_cmd
);

    op_t rd_op;
    op_t wr_op;
    op_t op;

    always_comb begin
        case (s_reg_offset)
            OFS_DATA: rd_op = OP_RD_RBR;
            OFS_IER:  rd_op = OP_RD_IER;
            OFS_IIR:  rd_op = OP_RD_IIR;
            OFS_LCR:  rd_op = OP_RD_LCR;
            OFS_MCR:  rd_op = OP_RD_MCR;
            OFS_LSR:  rd_op = OP_RD_LSR;
            OFS_MSR:  rd_op = OP_RD_MSR;
            default:  rd_op = OP_RD_SCR;
        endcase
    end

    always_comb begin
        case (s_reg_offset)
            OFS_DATA: wr_op = OP_WR_THR;
            OFS_IER:  wr_op = OP_WR_IER;
            OFS_IIR:  wr_op = OP_WR_FCR;
            OFS_LCR:  wr_op = OP_WR_LCR;
            OFS_MCR:  wr_op = OP_WR_MCR;
            OFS_SCR:  wr_op = OP_WR_SCR;
            default:  wr_op = OP_WR_NONE;
        endcase
    end

    always_comb begin
        case (s_mode)
            MODE_READ:  op = rd_op;
            MODE_WRITE: op = wr_op;
            MODE_RX:    op = OP_LINE_RX;
            default:    op = OP_TX_TAKE;
        endcase
    end

    assign s_ready    = !q_full;
    assign q_push     = s_valid && !q_full;
    assign q_cmd.op   = op;
    assign q_cmd.data = s_data;

endmodule

### hw/rtl/u8250_cmdq.sv
// ----------------------------------------------------------------------------
// u8250_cmdq
// Two-entry command queue decoupling the front decoder from the back end.
// ----------------------------------------------------------------------------
module u8250_cmdq import u8250_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               push,
    input  cmd_t               push_cmd,
    input  logic               pop,
    output logic               head_valid,
    output cmd_t               head_cmd,
    output logic               full,
    output logic [Q_CNT_W-1:0] count
);

    cmd_t               slot_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [Q_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [Q_CNT_W-1:0] count_reg, count_next;

    function automatic logic [Q_PTR_W-1:0] ptr_inc(input logic [Q_PTR_W-1:0] p);
        ptr_inc = (p == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    always_comb begin
        wr_ptr_next = push ? ptr_inc(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = pop  ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    assign head_valid = (count_reg != '0);
    assign head_cmd   = slot_reg[rd_ptr_reg];
    assign full       = (count_reg == Q_CNT_W'(Q_DEPTH));
    assign count      = count_reg;

endmodule

### hw/rtl/u8250_back.sv
// ----------------------------------------------------------------------------
// u8250_back
// Executes one command per cycle when the output is not stalled, against the
// UART registers and receive ring; the result is held in the output register.
// ----------------------------------------------------------------------------
module u8250_back import u8250_pkg::*; #(
    parameter int RX_DEPTH = 16
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cmd_valid,
    input  cmd_t       cmd,
    output logic       cmd_pop,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_read_data,
    output logic       m_irq_line,
    output logic       m_output_pending,
    output bk_stat_t   stat
);

    localparam int PTR_W = (RX_DEPTH > 1) ? $clog2(RX_DEPTH) : 1;

    typedef struct packed {
        logic [7:0] iir;
        logic       irq;
    } irq_eval_t;

    logic [15:0] dl_reg, dl_next;
    logic [7:0]  lcr_reg, lcr_next;
    logic [3:0]  ier_reg, ier_next;
    logic [4:0]  mcr_reg, mcr_next;
    logic [7:0]  lsr_reg, lsr_next;
    logic [7:0]  msr_reg, msr_next;
    logic [7:0]  iir_reg, iir_next;
    logic [7:0]  scr_reg, scr_next;
    logic [7:0]  fcr_reg, fcr_next;
    logic [7:0]  thr_reg, thr_next;
    logic [7:0]  rbr_reg, rbr_next;
    logic        irq_reg, irq_next;
    logic [PTR_W-1:0] rx_rd_ptr_reg, rx_rd_ptr_next;
    logic [PTR_W-1:0] rx_wr_ptr_reg, rx_wr_ptr_next;

    logic       m_valid_reg, m_valid_next;
    logic [7:0] m_read_data_reg, m_read_data_next;
    logic       m_irq_line_reg, m_irq_line_next;
    logic       m_pend_reg, m_pend_next;

    logic [7:0] ring_mem [RX_DEPTH];
    logic [7:0] ring_rd_data_reg;
    logic       bypass_hit_reg;
    logic [7:0] bypass_data_reg;
    logic [7:0] ring_head;
    logic       ring_we;
    logic [PTR_W-1:0] wr_ptr_inc;
    logic [PTR_W-1:0] rd_ptr_inc;

    logic       fire;
    logic       dlab;
    logic       do_eval;
    logic [7:0] rd;
    irq_eval_t  ev;

    function automatic logic [PTR_W-1:0] ring_inc(input logic [PTR_W-1:0] p);
        ring_inc = (p == PTR_W'(RX_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    // interrupt priority: received data first, then holding register empty
    function automatic irq_eval_t irq_eval(input logic [4:0] mcr, input logic [3:0] ier,
                                           input logic [7:0] lsr, input logic irq_cur);
        irq_eval_t r;
        r.iir = IIR_NONE;
        r.irq = 1'b0;
        if (!mcr[MCR_OUT2_BIT]) begin
            r.irq = irq_cur;
        end else if (ier[IER_RX_BIT] && lsr[LSR_DR_BIT]) begin
            r.iir = IIR_RDA;
            r.irq = 1'b1;
        end else if (ier[IER_TX_BIT] && lsr[LSR_THRE_BIT]) begin
            r.iir = IIR_THRE;
            r.irq = 1'b1;
        end
        irq_eval = r;
    endfunction

    assign fire       = cmd_valid && (!m_valid_reg || m_ready);
    assign cmd_pop    = fire;
    assign dlab       = lcr_reg[LCR_DLAB_BIT];
    assign ring_head  = bypass_hit_reg ? bypass_data_reg : ring_rd_data_reg;
    assign wr_ptr_inc = ring_inc(rx_wr_ptr_reg);
    assign rd_ptr_inc = ring_inc(rx_rd_ptr_reg);

    always_comb begin
        dl_next        = dl_reg;
        lcr_next       = lcr_reg;
        ier_next       = ier_reg;
        mcr_next       = mcr_reg;
        lsr_next       = lsr_reg;
        msr_next       = msr_reg;
        scr_next       = scr_reg;
        fcr_next       = fcr_reg;
        thr_next       = thr_reg;
        rbr_next       = rbr_reg;
        rx_rd_ptr_next = rx_rd_ptr_reg;
        rx_wr_ptr_next = rx_wr_ptr_reg;
        ring_we        = 1'b0;
        do_eval        = 1'b0;
        rd             = 8'h00;

        if (fire) begin
            case (cmd.op)
                OP_RD_RBR: begin
                    if (dlab) begin
                        rd = dl_reg[7:0];
                    end else begin
                        if (rx_rd_ptr_reg != rx_wr_ptr_reg) begin
                            rbr_next       = ring_head;
                            rx_rd_ptr_next = rd_ptr_inc;
                            if (rd_ptr_inc == rx_wr_ptr_reg) begin
                                lsr_next[LSR_DR_BIT] = 1'b0;
                            end
                        end
                        do_eval = 1'b1;
                        rd      = rbr_next;
                    end
                end
                OP_RD_IER: rd = dlab ? dl_reg[15:8] : {4'h0, ier_reg};
                OP_RD_IIR: rd = iir_reg;
                OP_RD_LCR: rd = lcr_reg;
                OP_RD_MCR: rd = {3'b000, mcr_reg};
                OP_RD_LSR: begin
                    rd       = lsr_reg;
                    lsr_next = lsr_reg & LSR_KEEP_MASK;
                end
                OP_RD_MSR: begin
                    // loopback: cts follows rts, dsr follows dtr
                    if (mcr_reg[MCR_LOOP_BIT]) begin
                        rd = {2'b00, mcr_reg[MCR_DTR_BIT], mcr_reg[MCR_RTS_BIT], 4'h0};
                    end else begin
                        rd = msr_reg;
                    end
                    msr_next = msr_reg & MSR_KEEP_MASK;
                end
                OP_RD_SCR: rd = scr_reg;
                OP_WR_THR: begin
                    if (dlab) begin
                        dl_next[7:0] = cmd.data;
                    end else begin
                        thr_next               = cmd.data;
                        lsr_next[LSR_THRE_BIT] = 1'b1;
                        lsr_next[LSR_TEMT_BIT] = 1'b1;
                        do_eval                = 1'b1;
                    end
                end
                OP_WR_IER: begin
                    if (dlab) begin
                        dl_next[15:8] = cmd.data;
                    end else begin
                        ier_next = cmd.data[3:0];
                    end
                    do_eval = 1'b1;
                end
                OP_WR_FCR: fcr_next = cmd.data;
                OP_WR_LCR: lcr_next = cmd.data;
                OP_WR_MCR: begin
                    mcr_next = cmd.data[4:0];
                    do_eval  = 1'b1;
                end
                OP_WR_SCR: scr_next = cmd.data;
                OP_LINE_RX: begin
                    if (wr_ptr_inc == rx_rd_ptr_reg) begin
                        lsr_next[LSR_OE_BIT] = 1'b1;
                    end else begin
                        ring_we              = 1'b1;
                        rx_wr_ptr_next       = wr_ptr_inc;
                        lsr_next[LSR_DR_BIT] = 1'b1;
                        do_eval              = 1'b1;
                    end
                end
                OP_TX_TAKE: begin
                    rd       = thr_reg;
                    thr_next = 8'h00;
                end
                default: ;
            endcase
        end

        ev = irq_eval(mcr_next, ier_next, lsr_next, irq_reg);
        iir_next = do_eval ? ev.iir : iir_reg;
        irq_next = do_eval ? ev.irq : irq_reg;

        m_valid_next     = fire ? 1'b1 : (m_valid_reg && !m_ready);
        m_read_data_next = fire ? rd : m_read_data_reg;
        m_irq_line_next  = fire ? irq_next : m_irq_line_reg;
        m_pend_next      = fire ? (!lsr_next[LSR_THRE_BIT] || (thr_next != 8'h00))
                                : m_pend_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dl_reg        <= DIVISOR_RST;
            lcr_reg       <= '0;
            ier_reg       <= '0;
            mcr_reg       <= '0;
            lsr_reg       <= LSR_RST;
            msr_reg       <= MSR_RST;
            iir_reg       <= IIR_NONE;
            scr_reg       <= '0;
            fcr_reg       <= '0;
            thr_reg       <= '0;
            rbr_reg       <= '0;
            irq_reg       <= 1'b0;
            rx_rd_ptr_reg <= '0;
            rx_wr_ptr_reg <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            dl_reg        <= dl_next;
            lcr_reg       <= lcr_next;
            ier_reg       <= ier_next;
            mcr_reg       <= mcr_next;
            lsr_reg       <= lsr_next;
            msr_reg       <= msr_next;
            iir_reg       <= iir_next;
            scr_reg       <= scr_next;
            fcr_reg       <= fcr_next;
            thr_reg       <= thr_next;
            rbr_reg       <= rbr_next;
            irq_reg       <= irq_next;
            rx_rd_ptr_reg <= rx_rd_ptr_next;
            rx_wr_ptr_reg <= rx_wr_ptr_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_read_data_reg <= m_read_data_next;
        m_irq_line_reg  <= m_irq_line_next;
        m_pend_reg      <= m_pend_next;
    end

    // receive ring: head word prefetched at the next read pointer,
    // with write-through when the new byte lands on that slot
    always_ff @(posedge aclk) begin
        if (ring_we) begin
            ring_mem[rx_wr_ptr_reg] <= cmd.data;
        end
        ring_rd_data_reg <= ring_mem[rx_rd_ptr_next];
        bypass_hit_reg   <= ring_we && (rx_wr_ptr_reg == rx_rd_ptr_next);
        bypass_data_reg  <= cmd.data;
    end

    assign m_valid          = m_valid_reg;
    assign m_read_data      = m_read_data_reg;
    assign m_irq_line       = m_irq_line_reg;
    assign m_output_pending = m_pend_reg;

    assign stat.thre = lsr_reg[LSR_THRE_BIT];
    assign stat.irq  = irq_reg;
    assign stat.iir  = iir_reg;

endmodule

### hw/rtl/uart_8250_register_model_top.sv
// ----------------------------------------------------------------------------
// uart_8250_register_model_top
// Emulated 8250 UART register file: host reads and writes, line receive into
// a ring buffer, and transmit byte removal, one result word per input word.
// ----------------------------------------------------------------------------
// path: queue slot, then the back end's output register holding its result
// throughput: 1 word per cycle unless m_ready stalls the output; the back end
//   executes one command per cycle unless its output register is stalled
// reset: synchronous active-low aresetn restores the UART registers, pointers
//   and output valid; the receive ring, queue slots and result data registers
//   are not cleared; the receive ring needs no clearing pass
module uart_8250_register_model_top import u8250_pkg::*; #(
    parameter int RX_DEPTH = 16
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [1:0] s_mode,
    input  logic [2:0] s_reg_offset,
    input  logic [7:0] s_data,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_read_data,
    output logic       m_irq_line,
    output logic       m_output_pending
);

    logic               q_full;
    logic               q_push;
    cmd_t               q_in_cmd;
    logic               q_pop;
    logic               q_head_valid;
    cmd_t               q_head_cmd;
    logic [Q_CNT_W-1:0] q_count;
    bk_stat_t           bk_stat;

    u8250_front u_front (
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_mode       (s_mode),
        .s_reg_offset (s_reg_offset),
        .s_data       (s_data),
        .q_full       (q_full),
        .q_push       (q_push),
        .q_cmd        (q_in_cmd)
    );

    u8250_cmdq u_cmdq (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_cmd   (q_in_cmd),
        .pop        (q_pop),
        .head_valid (q_head_valid),
        .head_cmd   (q_head_cmd),
        .full       (q_full),
        .count      (q_count)
    );

    u8250_back #(
        .RX_DEPTH (RX_DEPTH)
    ) u_back (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cmd_valid        (q_head_valid),
        .cmd              (q_head_cmd),
        .cmd_pop          (q_pop),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_read_data      (m_read_data),
        .m_irq_line       (m_irq_line),
        .m_output_pending (m_output_pending),
        .stat             (bk_stat)
    );

`ifndef SYNTH
    // an accepted word is held in the queue on the next cycle
    a_accept_queued: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> (q_count != '0))
        else $error("accepted word missing from command queue");

    // an active identification code always comes with the interrupt line
    a_iir_irq: assert property (@(posedge aclk) disable iff (!aresetn)
        ((bk_stat.iir == IIR_RDA) || (bk_stat.iir == IIR_THRE)) |-> bk_stat.irq)
        else $error("interrupt identified but line low");

    // identification register holds exactly one code bit
    a_iir_code: assert property (@(posedge aclk) disable iff (!aresetn)
        (bk_stat.iir[7:3] == 5'd0) && $onehot(bk_stat.iir[2:0]))
        else $error("bad interrupt identification value");

    // transmit completes at once, so the holding register never reads busy
    a_thre_set: assert property (@(posedge aclk) disable iff (!aresetn)
        bk_stat.thre)
        else $error("transmit holding empty flag cleared");
`endif

endmodule

### tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the 8250 register model. A short table of directed
// words covers reset values, divisor access, masking, loopback and the receive
// ring filling past capacity. Random register traffic and line bytes follow
// under four flow-control phases. Every result word is compared against an
// in-bench model of the register file, or against the table for typed rows.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import u8250_pkg::*;

    localparam int CLK_PERIOD   = 20;
    localparam int RING_DEPTH   = 16;
    localparam int RING_AW      = $clog2(RING_DEPTH);
    localparam int RANDOM_WORDS = 490;
    localparam int LIMIT_CYCLES = 200000;
    localparam int DRAIN_CYCLES = 8;
    localparam int NUM_DIR      = 29;

    localparam logic [7:0] IER_MASK = 8'h0F;
    localparam logic [7:0] MCR_MASK = 8'h1F;

    typedef struct packed {
        logic [7:0] read_data;
        logic       irq;
        logic       pending;
    } uart_result_t;

    typedef struct packed {
        logic [1:0] mode;
        logic [2:0] ofs;
        logic [7:0] data;
        logic [4:0] reps;
        logic       typed;
        logic [7:0] rd;
        logic       irq;
        logic       pend;
    } stim_row_t;

    logic       aclk = 1'b0;
    logic       aresetn = 1'b0;
    logic       s_valid = 1'b0;
    logic       s_ready;
    logic [1:0] s_mode = MODE_READ;
    logic [2:0] s_reg_offset = OFS_DATA;
    logic [7:0] s_data = 8'h00;
    logic       m_valid;
    logic       m_ready = 1'b0;
    logic [7:0] m_read_data;
    logic       m_irq_line;
    logic       m_output_pending;

    // register file as the host sees it
    logic [15:0]        dl_reg;
    logic [7:0]         lcr_reg;
    logic [3:0]         ier_reg;
    logic [4:0]         mcr_reg;
    logic [7:0]         lsr_reg;
    logic [7:0]         msr_reg;
    logic [7:0]         iir_reg;
    logic [7:0]         scr_reg;
    logic [7:0]         fcr_reg;
    logic [7:0]         thr_reg;
    logic [7:0]         rbr_reg;
    logic [7:0]         rx_ring [RING_DEPTH];
    logic [RING_AW-1:0] rx_rd;
    logic [RING_AW-1:0] rx_wr;
    logic               irq_reg;

    uart_result_t resp_q [$];
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int counted_words = 0;
    int results_checked = 0;
    int mismatches = 0;
    int rx_dropped = 0;
    int cycle_cnt = 0;

    stim_row_t directed_tab [NUM_DIR] = '{
        '{MODE_READ,  OFS_IIR,  8'h00, 5'd1,  1'b1, IIR_NONE, 1'b0, 1'b0},
        '{MODE_READ,  OFS_LSR,  8'h00, 5'd1,  1'b1, LSR_RST, 1'b0, 1'b0},
        '{MODE_READ,  OFS_MSR,  8'h00, 5'd1,  1'b1, MSR_RST, 1'b0, 1'b0},
        // empty ring read returns the last byte read
        '{MODE_READ,  OFS_DATA, 8'h00, 5'd1,  1'b1, 8'h00, 1'b0, 1'b0},
        '{MODE_WRITE, OFS_LCR,  8'h80, 5'd1,  1'b0, 8'h00, 1'b0, 1'b0},
        '{MODE_READ,  OFS_DATA, 8'h00, 5'd1,  1'b1, DIVISOR_RST[7:0], 1'b0, 1'b0},
        '{MODE_READ,  OFS_IER,  8'h00, 5'd1,  1'b1, DIVISOR_RST[15:8], 1'b0, 1'b0},
        '{MODE_WRITE, OFS_DATA, 8'hFF, 5'd1,  1'b0, 8'h00, 1'b0, 1'b0},
        '{MODE_WRITE, OFS_IER,  8'hFF, 5'd1,  1'b0, 8'h00, 1'b0, 1'b0},
        '{MODE_READ,  OFS_IER,  8'h00, 5'd1,  1'b0, 8'h00, 1'b0, 1'b0},
        '{MODE_WRITE, OFS_LCR,  8'h03, 5'd1,  1'b0, 8'h00, 1'b0, 1'b0},
        '{MODE_WRITE, OFS_IER,  8'hFF, 5'd1,  1'b0, 8'h00, 1'b0, 1'b0},
        '{MODE_WRITE, OFS_MCR,  8'hFF, 5'd1,  1'b0, 8'h00, 1'b0, 1'b0},
        // loopback msr
        '{MODE_READ,  OFS_MSR,  8'h00, 5'd1,  1'b0, 8'h00, 1'b0, 1'b0},
        '{MODE_WRITE, OFS_IIR,  8'hC7, 5'd1,  1'b0, 8'h00, 1'b0, 1'b0},
        '{MODE_WRITE, OFS_LSR,  8'hFF, 5'd1,  1'b0, 8'h00, 1'b0, 1'b0},
        '{MODE_WRITE, OFS_MSR,  8'hFF, 5'd1,  1'b0, 8'h00, 1'b0, 1'b0},
        '{MODE_WRITE, OFS_SCR,  8'hA5, 5'd1,  1'b0, 8'h00, 1'b0, 1'b0},
        '{MODE_READ,  OFS_SCR,  8'h00, 5'd1,  1'b0, 8'h00, 1'b0, 1'b0},
        '{MODE_WRITE, OFS_DATA, 8'h00, 5'd1,  1'b0, 8'h00, 1'b0, 1'b0},
        '{MODE_WRITE, OFS_DATA, 8'h5A, 5'd1,  1'b0, 8'h00, 1'b0, 1'b0},
        '{MODE_TAKE,  OFS_DATA, 8'h00, 5'd1,  1'b0, 8'h00, 1'b0, 1'b0},
        '{MODE_TAKE,  OFS_DATA, 8'h00, 5'd1,  1'b0, 8'h00, 1'b0, 1'b0},
        // sixteen line bytes 00..ff, the last one overruns
        '{MODE_RX,    OFS_DATA, 8'h00, 5'd16, 1'b0, 8'h00, 1'b0, 1'b0},
        '{MODE_READ,  OFS_LSR,  8'h00, 5'd1,  1'b0, 8'h00, 1'b0, 1'b0},
        '{MODE_READ,  OFS_IIR,  8'h00, 5'd1,  1'b0, 8'h00, 1'b0, 1'b0},
        '{MODE_READ,  OFS_DATA, 8'h00, 5'd16, 1'b0, 8'h00, 1'b0, 1'b0},
        // out2 cleared: iir drops to none, irq level holds
        '{MODE_WRITE, OFS_MCR,  8'h00, 5'd1,  1'b0, 8'h00, 1'b0, 1'b0},
        '{MODE_READ,  OFS_IIR,  8'h00, 5'd1,  1'b0, 8'h00, 1'b0, 1'b0}
    };

    uart_8250_register_model_top #(
        .RX_DEPTH(RING_DEPTH)
    ) u_top (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_mode          (s_mode),
        .s_reg_offset    (s_reg_offset),
        .s_data          (s_data),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_read_data     (m_read_data),
        .m_irq_line      (m_irq_line),
        .m_output_pending(m_output_pending)
    );

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    function automatic void uart_reset_regs();
        dl_reg  = DIVISOR_RST;
        lcr_reg = 8'h00;
        ier_reg = 4'h0;
        mcr_reg = 5'h00;
        lsr_reg = LSR_RST;
        msr_reg = MSR_RST;
        iir_reg = IIR_NONE;
        scr_reg = 8'h00;
        fcr_reg = 8'h00;
        thr_reg = 8'h00;
        rbr_reg = 8'h00;
        rx_rd   = '0;
        rx_wr   = '0;
        irq_reg = 1'b0;
    endfunction

    function automatic void update_irq();
        if (!mcr_reg[MCR_OUT2_BIT]) begin
            iir_reg = IIR_NONE;
        end else if (ier_reg[IER_RX_BIT] && lsr_reg[LSR_DR_BIT]) begin
            iir_reg = IIR_RDA;
            irq_reg = 1'b1;
        end else if (ier_reg[IER_TX_BIT] && lsr_reg[LSR_THRE_BIT]) begin
            iir_reg = IIR_THRE;
            irq_reg = 1'b1;
        end else begin
            iir_reg = IIR_NONE;
            irq_reg = 1'b0;
        end
    endfunction

    function automatic uart_result_t uart_predict(logic [1:0] mode, logic [2:0] ofs,
                                                  logic [7:0] d);
        uart_result_t r;
        logic [RING_AW-1:0] nx;
        r.read_data = 8'h00;
        case (mode)
            MODE_READ: begin
                case (ofs)
                    OFS_DATA: begin
                        if (lcr_reg[LCR_DLAB_BIT]) begin
                            r.read_data = dl_reg[7:0];
                        end else begin
                            if (rx_rd != rx_wr) begin
                                rbr_reg = rx_ring[rx_rd];
                                rx_rd = rx_rd + 1'b1;
                                if (rx_rd == rx_wr) lsr_reg[LSR_DR_BIT] = 1'b0;
                            end
                            update_irq();
                            r.read_data = rbr_reg;
                        end
                    end
                    OFS_IER: r.read_data = lcr_reg[LCR_DLAB_BIT] ? dl_reg[15:8] : {4'h0, ier_reg};
                    OFS_IIR: r.read_data = iir_reg;
                    OFS_LCR: r.read_data = lcr_reg;
                    OFS_MCR: r.read_data = {3'b000, mcr_reg};
                    OFS_LSR: begin
                        r.read_data = lsr_reg;
                        lsr_reg = lsr_reg & LSR_KEEP_MASK;
                    end
                    OFS_MSR: begin
                        if (mcr_reg[MCR_LOOP_BIT])
                            r.read_data = {2'b00, mcr_reg[MCR_DTR_BIT], mcr_reg[MCR_RTS_BIT], 4'h0};
                        else
                            r.read_data = msr_reg;
                        msr_reg = msr_reg & MSR_KEEP_MASK;
                    end
                    default: r.read_data = scr_reg;
                endcase
            end
            MODE_WRITE: begin
                case (ofs)
                    OFS_DATA: begin
                        if (lcr_reg[LCR_DLAB_BIT]) begin
                            dl_reg[7:0] = d;
                        end else begin
                            thr_reg = d;
                            lsr_reg[LSR_THRE_BIT] = 1'b1;
                            lsr_reg[LSR_TEMT_BIT] = 1'b1;
                            update_irq();
                        end
                    end
                    OFS_IER: begin
                        if (lcr_reg[LCR_DLAB_BIT]) dl_reg[15:8] = d;
                        else ier_reg = 4'(d & IER_MASK);
                        update_irq();
                    end
                    OFS_IIR: fcr_reg = d;
                    OFS_LCR: lcr_reg = d;
                    OFS_MCR: begin
                        mcr_reg = 5'(d & MCR_MASK);
                        update_irq();
                    end
                    OFS_SCR: scr_reg = d;
                    default: ;
                endcase
            end
            MODE_RX: begin
                nx = rx_wr + 1'b1;
                if (nx == rx_rd) begin
                    lsr_reg[LSR_OE_BIT] = 1'b1;
                    rx_dropped++;
                end else begin
                    rx_ring[rx_wr] = d;
                    rx_wr = nx;
                    lsr_reg[LSR_DR_BIT] = 1'b1;
                    update_irq();
                end
            end
            default: begin
                r.read_data = thr_reg;
                thr_reg = 8'h00;
            end
        endcase
        r.irq = irq_reg;
        r.pending = !lsr_reg[LSR_THRE_BIT] || (thr_reg != 8'h00);
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [7:0] want,
                                   input logic [7:0] got);
        $display("mismatch on %s: expected %02h, got %02h (result word %0d, cycle %0d)",
                 what, want, got, results_checked, cycle_cnt);
        mismatches++;
    endtask

    // holds valid until accepted; the expectation is worked out at acceptance
    task automatic send_word(input logic [1:0] mode, input logic [2:0] ofs,
                             input logic [7:0] d, input bit typed = 1'b0,
                             input uart_result_t want = '0);
        uart_result_t got;
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_mode       <= mode;
        s_reg_offset <= ofs;
        s_data       <= d;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        got = uart_predict(mode, ofs, d);
        resp_q.push_back(typed ? want : got);
        counted_words++;
    endtask

    task automatic check_result();
        uart_result_t want;
        if (resp_q.size() == 0) begin
            report_mismatch("unexpected word", 8'h00, m_read_data);
            return;
        end
        want = resp_q.pop_front();
        results_checked++;
        if (m_read_data !== want.read_data)
            report_mismatch("read_data", want.read_data, m_read_data);
        if (m_irq_line !== want.irq)
            report_mismatch("irq_line", {7'd0, want.irq}, {7'd0, m_irq_line});
        if (m_output_pending !== want.pending)
            report_mismatch("output_pending", {7'd0, want.pending}, {7'd0, m_output_pending});
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) check_result();
        m_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > LIMIT_CYCLES) begin
            $display("timeout after %0d cycles, %0d words still expected",
                     cycle_cnt, resp_q.size());
            $display("FAILED: results differ");
            $finish;
        end
    end

    task automatic random_sequence();
        int kind;
        int len;
        logic [1:0] mode;
        logic [2:0] ofs;
        logic [7:0] d;
        kind = $urandom_range(99);
        if (kind < 8) begin
            // line burst, often long enough to fill the ring
            len = $urandom_range(20, 4);
            repeat (len) send_word(MODE_RX, OFS_DATA, 8'($urandom));
        end else if (kind < 16) begin
            // clear dlab, then drain the ring
            send_word(MODE_WRITE, OFS_LCR, 8'($urandom) & 8'h7F);
            len = $urandom_range(18, 2);
            repeat (len) send_word(MODE_READ, OFS_DATA, 8'($urandom));
        end else if (kind < 24) begin
            send_word(MODE_WRITE, OFS_DATA, 8'($urandom));
            if ($urandom_range(1)) send_word(MODE_READ, 3'($urandom), 8'($urandom));
            send_word(MODE_TAKE, 3'($urandom), 8'($urandom));
        end else if (kind < 30) begin
            send_word(MODE_WRITE, OFS_IER, 8'($urandom));
            d = 8'($urandom);
            d[MCR_OUT2_BIT] = ($urandom_range(99) < 70);
            send_word(MODE_WRITE, OFS_MCR, d);
        end else begin
            mode = 2'($urandom);
            ofs  = 3'($urandom);
            d    = 8'($urandom);
            if (mode == MODE_READ && $urandom_range(99) < 40) ofs = OFS_DATA;
            if (mode == MODE_WRITE && ofs == OFS_LCR && $urandom_range(99) < 80)
                d[LCR_DLAB_BIT] = 1'b0;
            send_word(mode, ofs, d);
        end
    endtask

    initial begin
        stim_row_t row;
        int dir_words;
        int seq_no;
        int phase;
        uart_reset_regs();
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        for (int r = 0; r < NUM_DIR; r++) begin
            row = directed_tab[r];
            for (int i = 0; i < int'(row.reps); i++)
                send_word(row.mode, row.ofs, row.data + 8'(i * 17), row.typed,
                          '{row.rd, row.irq, row.pend});
        end
        dir_words = counted_words;

        seq_no = 0;
        while (counted_words < dir_words + RANDOM_WORDS) begin
            phase = (counted_words - dir_words) * 4 / RANDOM_WORDS;
            if (seq_no % 10 < 2) begin
                send_idle_pct  = 0;
                recv_stall_pct = 0;
            end else begin
                case (phase)
                    0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                    1: begin send_idle_pct = 68; recv_stall_pct = 0;  end
                    2: begin send_idle_pct = 0;  recv_stall_pct = 68; end
                    default: begin send_idle_pct = 35; recv_stall_pct = 35; end
                endcase
            end
            random_sequence();
            seq_no++;
        end
        s_valid <= 1'b0;

        while (resp_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("sent %0d words (%0d from the directed table) over four flow-control phases",
                 counted_words, dir_words);
        $display("checked %0d result words, %0d line bytes dropped on a full ring",
                 results_checked, rx_dropped);
        if (mismatches == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
